// ===== src/hts_pkg.sv =====
// Package for the hysteresis thermostat: op, mode and relay codes, plus the
// constant-divisor temperature and setpoint conversions.
// Depends on nothing; used by src/hysteresis_thermostat_fsm.sv.
package hts_pkg;

  typedef logic [2:0] op_t;
  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_UP    = 3'd1;
  localparam op_t OP_DOWN  = 3'd2;
  localparam op_t OP_MODE  = 3'd3;
  localparam op_t OP_UNITS = 3'd4;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_OFF  = 2'd0;
  localparam mode_t MODE_HEAT = 2'd1;
  localparam mode_t MODE_COOL = 2'd2;

  typedef logic [1:0] change_t;
  localparam change_t CHG_NONE = 2'd0;
  localparam change_t CHG_ON   = 2'd1;
  localparam change_t CHG_OFF  = 2'd2;

  typedef enum logic [4:0] {
    RELAY_HEAT_OFF = 5'b00001,
    RELAY_HEAT_ON  = 5'b00010,
    RELAY_COOL_OFF = 5'b00100,
    RELAY_COOL_ON  = 5'b01000,
    RELAY_OFF      = 5'b10000
  } relay_e;

  typedef logic signed [9:0]  setpt_t;
  typedef logic signed [12:0] temp_t;

  localparam setpt_t HEAT_DAY_RST   = 10'sd75;
  localparam setpt_t COOL_DAY_RST   = 10'sd65;
  localparam setpt_t HEAT_NIGHT_RST = 10'sd80;
  localparam setpt_t COOL_NIGHT_RST = 10'sd70;

  localparam logic [4:0] LATE_HOUR      = 5'd23;
  localparam logic [4:0] MORNING_HOUR   = 5'd6;

  localparam logic signed [13:0] SET_HI = 14'sd511;
  localparam logic signed [13:0] SET_LO = -14'sd511;

  // Reciprocals: floor(a / 9) = (a * 58255) >> 19 for a < 2^15, and
  // floor(a / 5) = (a * 13108) >> 16 for a < 2^13.
  localparam logic [15:0] DIV9_MUL = 16'd58255;
  localparam logic [13:0] DIV5_MUL = 14'd13108;

  function automatic logic [11:0] div9(input logic [14:0] a);
    logic [30:0] p;
    p = 31'(a) * 31'(DIV9_MUL);
    return p[30:19];
  endfunction

  function automatic logic [10:0] div5(input logic [12:0] a);
    logic [26:0] p;
    p = 27'(a) * 27'(DIV5_MUL);
    return p[26:16];
  endfunction

  function automatic setpt_t clamp_set(input logic signed [13:0] v);
    setpt_t r;
    if (v > SET_HI) begin
      r = SET_HI[9:0];
    end else if (v < SET_LO) begin
      r = SET_LO[9:0];
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  // Fahrenheit to Celsius, truncated toward zero.
  function automatic setpt_t to_celsius(input setpt_t s);
    logic signed [13:0] p;
    logic [14:0]        mag;
    logic [11:0]        q;
    logic signed [13:0] r;
    p   = (14'(s) - 14'sd32) * 14'sd5;
    mag = p[13] ? 15'(-p) : 15'(p);
    q   = div9(mag);
    r   = p[13] ? $signed(-14'(q)) : $signed(14'(q));
    return clamp_set(r);
  endfunction

  // Celsius to Fahrenheit, truncated toward zero.
  function automatic setpt_t to_fahrenheit(input setpt_t s);
    logic signed [13:0] p;
    logic [12:0]        mag;
    logic [10:0]        q;
    logic signed [13:0] r;
    p   = 14'(s) * 14'sd9 + 14'sd160;
    mag = p[13] ? 13'(-p) : 13'(p);
    q   = div5(mag);
    r   = p[13] ? $signed(-14'(q)) : $signed(14'(q));
    return clamp_set(r);
  endfunction

  // Sample in sixteenths of a degree Fahrenheit to sixteenths Celsius.
  function automatic temp_t temp_to_celsius(input temp_t t);
    logic signed [15:0] p;
    logic [14:0]        mag;
    logic [11:0]        q;
    p   = (16'(t) - 16'sd512) * 16'sd5;
    mag = p[15] ? 15'(-p) : 15'(p);
    q   = div9(mag);
    return p[15] ? $signed(-13'(q)) : $signed(13'(q));
  endfunction

endpackage

// ===== src/hysteresis_thermostat_fsm.sv =====
// Hysteresis thermostat controller: setpoint, mode and unit state with a
// one-hot relay state machine. Depends on src/hts_pkg.sv.
// An accepted transaction enters the input stage, then its result the result
// register. Throughput: one transaction per cycle unless the output stalls; an
// input register feeds one combinational update into state and result registers.
// Reset (asynchronous, active low): day, Fahrenheit, mode off, relay heat-off,
// setpoints 75/65 day and 80/70 night, last temperature zero, both stages empty.
module hysteresis_thermostat_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hts_pkg::op_t          op_i,
  input  hts_pkg::temp_t        temp_sample_i,
  input  logic [4:0]            hour_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  heater_on_o,
  output logic                  cooler_on_o,
  output hts_pkg::mode_t        mode_now_o,
  output logic                  night_now_o,
  output logic                  celsius_now_o,
  output hts_pkg::setpt_t       active_setpoint_o,
  output hts_pkg::temp_t        shown_temp_o,
  output hts_pkg::change_t      relay_change_o
);
  import hts_pkg::*;

  // Input stage.
  logic       s1_valid_q;
  op_t        s1_op_q;
  temp_t      s1_temp_q;
  logic [4:0] s1_hour_q;
  logic       in_accept;
  logic       out_free;
  logic       s1_adv;

  // Controller state.
  relay_e relay_q, relay_d;
  mode_t  mode_q, mode_d;
  logic   celsius_q, celsius_d;
  logic   night_q, night_d;
  setpt_t heat_day_q, heat_day_d;
  setpt_t cool_day_q, cool_day_d;
  setpt_t heat_night_q, heat_night_d;
  setpt_t cool_night_q, cool_night_d;
  temp_t  last_temp_q, last_temp_d;

  // Result register.
  logic    out_valid_q;
  setpt_t  active_q, active_d;
  change_t change_q, change_d;

  logic               was_on;
  logic               now_on;
  setpt_t             step_sp;
  logic signed [15:0] t_ext;
  logic signed [15:0] thr_hi;
  logic signed [15:0] thr_lo;
  setpt_t             nudge;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    relay_d      = relay_q;
    mode_d       = mode_q;
    celsius_d    = celsius_q;
    night_d      = night_q;
    heat_day_d   = heat_day_q;
    cool_day_d   = cool_day_q;
    heat_night_d = heat_night_q;
    cool_night_d = cool_night_q;
    last_temp_d  = last_temp_q;
    nudge        = (s1_op_q == OP_UP) ? 10'sd1 : -10'sd1;

    // The tick path: new night flag first, then the converted sample.
    if (s1_op_q == OP_TICK) begin
      night_d     = (s1_hour_q == LATE_HOUR) || (s1_hour_q < MORNING_HOUR);
      last_temp_d = celsius_q ? temp_to_celsius(s1_temp_q) : s1_temp_q;
    end

    case (mode_q)
      MODE_COOL: step_sp = night_d ? cool_night_q : cool_day_q;
      default:   step_sp = night_d ? heat_night_q : heat_day_q;
    endcase
    t_ext  = 16'(last_temp_d);
    thr_hi = (16'(step_sp) + 16'sd1) <<< 4;
    thr_lo = (16'(step_sp) - 16'sd1) <<< 4;

    case (s1_op_q)
      OP_TICK: begin
        case (mode_q)
          MODE_OFF: relay_d = RELAY_OFF;
          MODE_COOL: begin
            case (relay_q)
              RELAY_COOL_OFF: if (t_ext > thr_hi) relay_d = RELAY_COOL_ON;
              RELAY_COOL_ON:  if (t_ext < thr_lo) relay_d = RELAY_COOL_OFF;
              default:        relay_d = RELAY_COOL_OFF;
            endcase
          end
          default: begin
            case (relay_q)
              RELAY_HEAT_OFF: if (t_ext < thr_lo) relay_d = RELAY_HEAT_ON;
              RELAY_HEAT_ON:  if (t_ext >= thr_hi) relay_d = RELAY_HEAT_OFF;
              default:        relay_d = RELAY_HEAT_OFF;
            endcase
          end
        endcase
      end
      OP_UP, OP_DOWN: begin
        if (night_q) begin
          heat_night_d = clamp_set(14'(heat_night_q) + 14'(nudge));
          cool_night_d = clamp_set(14'(cool_night_q) + 14'(nudge));
        end else begin
          heat_day_d = clamp_set(14'(heat_day_q) + 14'(nudge));
          cool_day_d = clamp_set(14'(cool_day_q) + 14'(nudge));
        end
      end
      OP_MODE: begin
        case (mode_q)
          MODE_OFF:  mode_d = MODE_HEAT;
          MODE_HEAT: mode_d = MODE_COOL;
          default:   mode_d = MODE_OFF;
        endcase
      end
      OP_UNITS: begin
        if (celsius_q) begin
          heat_day_d   = to_fahrenheit(heat_day_q);
          cool_day_d   = to_fahrenheit(cool_day_q);
          heat_night_d = to_fahrenheit(heat_night_q);
          cool_night_d = to_fahrenheit(cool_night_q);
        end else begin
          heat_day_d   = to_celsius(heat_day_q);
          cool_day_d   = to_celsius(cool_day_q);
          heat_night_d = to_celsius(heat_night_q);
          cool_night_d = to_celsius(cool_night_q);
        end
        celsius_d = !celsius_q;
      end
      default: begin
        // Unused op codes leave the state alone.
      end
    endcase

    was_on = (relay_q == RELAY_HEAT_ON) || (relay_q == RELAY_COOL_ON);
    now_on = (relay_d == RELAY_HEAT_ON) || (relay_d == RELAY_COOL_ON);
    if (!was_on && now_on) begin
      change_d = CHG_ON;
    end else if (was_on && !now_on) begin
      change_d = CHG_OFF;
    end else begin
      change_d = CHG_NONE;
    end

    case (mode_d)
      MODE_HEAT: active_d = night_d ? heat_night_d : heat_day_d;
      MODE_COOL: active_d = night_d ? cool_night_d : cool_day_d;
      default:   active_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      relay_q      <= RELAY_HEAT_OFF;
      mode_q       <= MODE_OFF;
      celsius_q    <= 1'b0;
      night_q      <= 1'b0;
      heat_day_q   <= HEAT_DAY_RST;
      cool_day_q   <= COOL_DAY_RST;
      heat_night_q <= HEAT_NIGHT_RST;
      cool_night_q <= COOL_NIGHT_RST;
      last_temp_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        relay_q      <= relay_d;
        mode_q       <= mode_d;
        celsius_q    <= celsius_d;
        night_q      <= night_d;
        heat_day_q   <= heat_day_d;
        cool_day_q   <= cool_day_d;
        heat_night_q <= heat_night_d;
        cool_night_q <= cool_night_d;
        last_temp_q  <= last_temp_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= op_i;
      s1_temp_q <= temp_sample_i;
      s1_hour_q <= hour_i;
    end
    if (s1_adv) begin
      active_q <= active_d;
      change_q <= change_d;
    end
  end

  // Status fields mirror the state registers, which only move with a result.
  assign out_valid_o       = out_valid_q;
  assign heater_on_o       = (relay_q == RELAY_HEAT_ON);
  assign cooler_on_o       = (relay_q == RELAY_COOL_ON);
  assign mode_now_o        = mode_q;
  assign night_now_o       = night_q;
  assign celsius_now_o     = celsius_q;
  assign active_setpoint_o = active_q;
  assign shown_temp_o      = last_temp_q;
  assign relay_change_o    = change_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled while the input stage is empty");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_op_q)))
    else $error("stalled input stage lost or changed its transaction");

  a_off_setpoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_now_o == MODE_OFF) |-> (active_setpoint_o == '0))
    else $error("active setpoint nonzero with mode off");

  a_change_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && relay_change_o == CHG_ON) |-> (heater_on_o || cooler_on_o))
    else $error("switch-on reported while no relay is on");

endmodule
